// ===== sv/cia_pkg.sv =====
// Package for the checked integer ALU: commands, status codes, sequencer states,
// request/result word types and the shared-unit request struct. No dependencies.
package cia_pkg;

	localparam int DEF_WIDTH = 64;

	typedef enum logic [3:0] {
		CMD_ADD = 4'd0,
		CMD_SUB = 4'd1,
		CMD_MUL = 4'd2,
		CMD_DIV = 4'd3,
		CMD_MOD = 4'd4,
		CMD_POW = 4'd5,
		CMD_AND = 4'd6,
		CMD_OR  = 4'd7,
		CMD_XOR = 4'd8,
		CMD_SHL = 4'd9,
		CMD_SHR = 4'd10,
		CMD_NEG = 4'd11
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_OVF     = 3'd1,
		ST_DIVZ    = 3'd2,
		ST_MODZ    = 3'd3,
		ST_INEXACT = 3'd4,
		ST_NEGEXP  = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MUL,
		S_DIV,
		S_SHF,
		S_POW_CHK,
		S_POW_ACC,
		S_POW_SQ
	} state_t;

	typedef struct packed {
		logic [3:0]         command;
		logic signed [63:0] left_operand;
		logic signed [63:0] right_operand;
	} req_word_t;

	typedef struct packed {
		logic signed [63:0] value;
		logic [2:0]         status;
	} res_word_t;

	typedef struct packed {
		logic start;
		logic div;
	} mdu_req_t;

endpackage

// ===== sv/cia_mdu.sv =====
// Shared iterative unit: shift-add multiply and restoring divide, one bit per cycle,
// both on a single adder. Depends on cia_pkg.
module cia_mdu #(
	parameter int WIDTH = cia_pkg::DEF_WIDTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cia_pkg::mdu_req_t req,
	input  logic [WIDTH-1:0]  x,
	input  logic [WIDTH-1:0]  y,
	output logic              done,
	output logic [WIDTH-1:0]  hi,
	output logic [WIDTH-1:0]  lo
);
	import cia_pkg::*;

	localparam int CW = $clog2(WIDTH);

	logic [WIDTH-1:0] hi_q, lo_q, y_q;
	logic             div_q, run_q, done_q;
	logic [CW-1:0]    cnt_q;
	logic [WIDTH:0]   op_a, op_b, rem_t;
	logic [WIDTH+1:0] sum;

	always_comb begin
		rem_t = {hi_q, lo_q[WIDTH-1]};
		op_a  = div_q ? rem_t : {1'b0, hi_q};
		op_b  = div_q ? ~{1'b0, y_q} : (lo_q[0] ? {1'b0, y_q} : '0);
		sum   = {1'b0, op_a} + {1'b0, op_b} + {{(WIDTH+1){1'b0}}, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(WIDTH - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			hi_q  <= '0;
			lo_q  <= x;
			y_q   <= y;
			div_q <= req.div;
		end else if (run_q) begin
			if (div_q) begin
				if (sum[WIDTH+1]) begin
					hi_q <= sum[WIDTH-1:0];
					lo_q <= {lo_q[WIDTH-2:0], 1'b1};
				end else begin
					hi_q <= rem_t[WIDTH-1:0];
					lo_q <= {lo_q[WIDTH-2:0], 1'b0};
				end
			end else begin
				hi_q <= sum[WIDTH:1];
				lo_q <= {sum[0], lo_q[WIDTH-1:1]};
			end
		end
	end

	assign done = done_q;
	assign hi   = hi_q;
	assign lo   = lo_q;

endmodule

// ===== sv/checked_integer_alu_core.sv =====
// Add, sub, logic ops and negate finish in the decode state; mul, div and mod run on the shared unit;
// shifts first reduce the amount modulo WIDTH a byte at a time; power takes up to 2*WIDTH multiplies.
// Throughput: one word at a time; busy stays high until the result strobe.
// The shared multiply/divide unit advances one bit per cycle.
// Reset (arst_n low, asynchronous) returns the sequencer to idle and drops done.
// Depends on cia_pkg and cia_mdu.
module checked_integer_alu_core #(
	parameter int WIDTH = cia_pkg::DEF_WIDTH
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cia_pkg::req_word_t request,
	output logic               busy,
	output logic               done,
	output cia_pkg::res_word_t result
);
	import cia_pkg::*;

	localparam int SW  = $clog2(WIDTH);
	localparam int ND  = (WIDTH + 7) / 8;
	localparam int DW  = 8 * ND;
	localparam int NW  = $clog2(ND + 1);
	localparam int RCP = ((1 << 20) + WIDTH - 1) / WIDTH;

	state_t                   state_q, state_d;
	cmd_t                     cmd_q;
	logic signed [WIDTH-1:0]  a_q, b_q, acc_q, base_q, acc_d, base_d;
	logic [WIDTH-1:0]         exp_q, exp_d, e_half;
	logic                     msign_q, msign_d;
	logic                     done_q, emit;
	status_t                  emit_st;
	logic signed [WIDTH-1:0]  emit_val;
	res_word_t                result_q;

	mdu_req_t                 mreq;
	logic [WIDTH-1:0]         ux, uy, mhi, mlo;
	logic                     mdone;

	logic [WIDTH-1:0]         mag_a, mag_b, mag_acc, mag_base;
	logic [WIDTH:0]           add_s, sub_s;
	logic                     mul_ovf;
	logic signed [WIDTH-1:0]  mul_val, min_v;
	logic [SW-1:0]            sh;

	logic [DW-1:0]            dig_q, dig_d;
	logic [6:0]               rem_q, rem_d;
	logic [NW-1:0]            dcnt_q, dcnt_d;
	logic [14:0]              red_x, red_r;
	logic [30:0]              red_p;
	logic [10:0]              red_qt;
	logic [17:0]              red_m;

	cia_mdu #(.WIDTH(WIDTH)) u_mdu (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mreq),
		.x     (ux),
		.y     (uy),
		.done  (mdone),
		.hi    (mhi),
		.lo    (mlo)
	);

	always_comb begin
		mag_a    = a_q[WIDTH-1] ? (~a_q + 1'b1) : a_q;
		mag_b    = b_q[WIDTH-1] ? (~b_q + 1'b1) : b_q;
		mag_acc  = acc_q[WIDTH-1] ? (~acc_q + 1'b1) : acc_q;
		mag_base = base_q[WIDTH-1] ? (~base_q + 1'b1) : base_q;
		add_s    = {a_q[WIDTH-1], a_q} + {b_q[WIDTH-1], b_q};
		sub_s    = {a_q[WIDTH-1], a_q} - {b_q[WIDTH-1], b_q};
		min_v    = {1'b1, {(WIDTH-1){1'b0}}};
		mul_ovf  = msign_q ? ((mhi != '0) || (mlo[WIDTH-1] && (mlo[WIDTH-2:0] != '0)))
		                   : ((mhi != '0) || mlo[WIDTH-1]);
		mul_val  = msign_q ? (~mlo + 1'b1) : mlo;
		red_x    = {rem_q, dig_q[DW-1 -: 8]};
		red_p    = 31'(red_x) * 31'(RCP);
		red_qt   = red_p[30:20];
		red_m    = 18'(red_qt) * 18'(WIDTH);
		red_r    = red_x - red_m[14:0];
		sh       = rem_q[SW-1:0];
		e_half   = exp_q >> 1;
	end

	always_comb begin
		state_d   = state_q;
		acc_d     = acc_q;
		base_d    = base_q;
		exp_d     = exp_q;
		msign_d   = msign_q;
		dig_d     = dig_q;
		rem_d     = rem_q;
		dcnt_d    = dcnt_q;
		emit      = 1'b0;
		emit_st   = ST_OK;
		emit_val  = '0;
		mreq      = '0;
		ux        = mag_a;
		uy        = mag_b;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_DECODE;
			end
			S_DECODE: begin
				emit = 1'b1;
				case (cmd_q)
					CMD_ADD: begin
						if (add_s[WIDTH] != add_s[WIDTH-1]) emit_st = ST_OVF;
						else emit_val = add_s[WIDTH-1:0];
					end
					CMD_SUB: begin
						if (sub_s[WIDTH] != sub_s[WIDTH-1]) emit_st = ST_OVF;
						else emit_val = sub_s[WIDTH-1:0];
					end
					CMD_MUL: begin
						emit       = 1'b0;
						mreq.start = 1'b1;
						msign_d    = a_q[WIDTH-1] ^ b_q[WIDTH-1];
						state_d    = S_MUL;
					end
					CMD_DIV, CMD_MOD: begin
						if (b_q == '0) begin
							emit_st = (cmd_q == CMD_DIV) ? ST_DIVZ : ST_MODZ;
						end else if (a_q == min_v && b_q == '1) begin
							emit_st = ST_OVF;
						end else begin
							emit       = 1'b0;
							mreq.start = 1'b1;
							mreq.div   = 1'b1;
							state_d    = S_DIV;
						end
					end
					CMD_POW: begin
						if (b_q[WIDTH-1]) begin
							emit_st = ST_NEGEXP;
						end else begin
							emit    = 1'b0;
							acc_d   = WIDTH'(1);
							base_d  = a_q;
							exp_d   = b_q;
							state_d = S_POW_CHK;
						end
					end
					CMD_AND: emit_val = a_q & b_q;
					CMD_OR:  emit_val = a_q | b_q;
					CMD_XOR: emit_val = a_q ^ b_q;
					CMD_SHL, CMD_SHR: begin
						emit    = 1'b0;
						dig_d   = DW'($unsigned(b_q));
						rem_d   = '0;
						dcnt_d  = '0;
						state_d = S_SHF;
					end
					CMD_NEG: begin
						if (a_q == min_v) emit_st = ST_OVF;
						else emit_val = -a_q;
					end
					default: emit_val = '0;
				endcase
				if (emit) state_d = S_IDLE;
			end
			S_MUL: begin
				if (mdone) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (mul_ovf) emit_st = ST_OVF;
					else emit_val = mul_val;
				end
			end
			S_DIV: begin
				if (mdone) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (cmd_q == CMD_DIV) begin
						if (mhi != '0) emit_st = ST_INEXACT;
						else emit_val = (a_q[WIDTH-1] ^ b_q[WIDTH-1]) ? (~mlo + 1'b1) : mlo;
					end else begin
						emit_val = a_q[WIDTH-1] ? (~mhi + 1'b1) : mhi;
					end
				end
			end
			S_SHF: begin
				if (dcnt_q == NW'(ND)) begin
					emit    = 1'b1;
					state_d = S_IDLE;
					if (cmd_q == CMD_SHL) emit_val = a_q << sh;
					else emit_val = a_q >>> sh;
				end else begin
					rem_d  = red_r[6:0];
					dig_d  = dig_q << 8;
					dcnt_d = dcnt_q + 1'b1;
				end
			end
			S_POW_CHK: begin
				if (exp_q == '0) begin
					emit     = 1'b1;
					emit_val = acc_q;
					state_d  = S_IDLE;
				end else if (exp_q[0]) begin
					mreq.start = 1'b1;
					ux         = mag_acc;
					uy         = mag_base;
					msign_d    = acc_q[WIDTH-1] ^ base_q[WIDTH-1];
					state_d    = S_POW_ACC;
				end else begin
					mreq.start = 1'b1;
					ux         = mag_base;
					uy         = mag_base;
					msign_d    = 1'b0;
					exp_d      = e_half;
					state_d    = S_POW_SQ;
				end
			end
			S_POW_ACC: begin
				if (mdone) begin
					if (mul_ovf) begin
						emit    = 1'b1;
						emit_st = ST_OVF;
						state_d = S_IDLE;
					end else if (e_half == '0) begin
						emit     = 1'b1;
						emit_val = mul_val;
						state_d  = S_IDLE;
					end else begin
						acc_d      = mul_val;
						exp_d      = e_half;
						mreq.start = 1'b1;
						ux         = mag_base;
						uy         = mag_base;
						msign_d    = 1'b0;
						state_d    = S_POW_SQ;
					end
				end
			end
			S_POW_SQ: begin
				if (mdone) begin
					if (mul_ovf) begin
						emit    = 1'b1;
						emit_st = ST_OVF;
						state_d = S_IDLE;
					end else begin
						base_d  = mul_val;
						state_d = S_POW_CHK;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q <= cmd_t'(request.command);
			a_q   <= request.left_operand[WIDTH-1:0];
			b_q   <= request.right_operand[WIDTH-1:0];
		end
		acc_q   <= acc_d;
		base_q  <= base_d;
		exp_q   <= exp_d;
		msign_q <= msign_d;
		dig_q   <= dig_d;
		rem_q   <= rem_d;
		dcnt_q  <= dcnt_d;
		if (emit) begin
			result_q.value  <= 64'(emit_val);
			result_q.status <= emit_st;
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== sv/cia_checker.sv =====
// Port-level checker for checked_integer_alu_core, attached by bind.
// Depends on cia_pkg.
module cia_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               start,
	input logic               busy,
	input logic               done,
	input cia_pkg::res_word_t result
);
	import cia_pkg::*;

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result strobe while busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (result.status != ST_OK) |-> (result.value == '0))
		else $error("nonzero value with error status");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.status <= ST_NEGEXP)) else $error("status code out of range");

endmodule

bind checked_integer_alu_core cia_checker u_cia_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.result(result)
);

// ===== test/checked_integer_alu_core_tb.sv =====
// Self-checking bench for checked_integer_alu_core at WIDTH 64: directed and random words,
// results predicted in SystemVerilog and compared in order. Depends on cia_pkg and the core.
module checked_integer_alu_core_tb;
	import cia_pkg::*;

	localparam longint MINV = 64'sh8000000000000000;
	localparam longint MAXV = 64'sh7fffffffffffffff;
	localparam int LIMIT = 25000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	req_word_t request = '0;
	logic busy, done;
	res_word_t result;

	req_word_t pending_words[$];
	res_word_t expected_results[$];
	int errors = 0;
	int gap = 0;
	int cycles = 0;
	bit stimulus_done = 1'b0;
	bit drain_hold = 1'b0;

	checked_integer_alu_core i_dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// safe product; returns 0 on overflow
	function automatic bit mul_fits(longint a, longint b, output longint p);
		logic signed [127:0] wide;
		wide = 128'(a) * 128'(b);
		p = wide[63:0];
		return wide == 128'(p);
	endfunction

	function automatic res_word_t alu_predict(req_word_t w);
		res_word_t r;
		longint a, b, acc, base, e, p;
		logic signed [127:0] wide;
		int sh;
		status_t st;
		a = w.left_operand;
		b = w.right_operand;
		sh = b[5:0];
		st = ST_OK;
		r.value = 0;
		case (w.command)
			CMD_ADD, CMD_SUB: begin
				wide = (w.command == CMD_ADD) ? 128'(a) + 128'(b) : 128'(a) - 128'(b);
				if (wide != 128'(longint'(wide[63:0]))) st = ST_OVF;
				else r.value = wide[63:0];
			end
			CMD_MUL: if (mul_fits(a, b, p)) r.value = p; else st = ST_OVF;
			CMD_DIV: begin
				if (b == 0) st = ST_DIVZ;
				else if (a == MINV && b == -1) st = ST_OVF;
				else if (a % b != 0) st = ST_INEXACT;
				else r.value = a / b;
			end
			CMD_MOD: begin
				if (b == 0) st = ST_MODZ;
				else if (a == MINV && b == -1) st = ST_OVF;
				else r.value = a % b;
			end
			CMD_POW: begin
				acc = 1;
				base = a;
				e = b;
				if (e < 0) st = ST_NEGEXP;
				while (st == ST_OK && e != 0) begin
					if (e[0]) begin
						if (mul_fits(acc, base, p)) acc = p; else st = ST_OVF;
					end
					e = e / 2;
					if (st == ST_OK && e != 0) begin
						if (mul_fits(base, base, p)) base = p; else st = ST_OVF;
					end
				end
				if (st == ST_OK) r.value = acc;
			end
			CMD_AND: r.value = a & b;
			CMD_OR: r.value = a | b;
			CMD_XOR: r.value = a ^ b;
			CMD_SHL: r.value = a << sh;
			CMD_SHR: r.value = a >>> sh;
			CMD_NEG: if (a == MINV) st = ST_OVF; else r.value = -a;
			default: ;
		endcase
		r.status = st;
		return r;
	endfunction

	function automatic longint rand_operand();
		longint v;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0: v = $signed(longint'($urandom_range(0, 20))) - 10;
			1: v = v >>> $urandom_range(0, 63);
			2: v = $urandom_range(0, 3) == 0 ? MINV : MAXV - $urandom_range(0, 2);
			3: v = longint'(1) << $urandom_range(0, 63);
			default: ;
		endcase
		return v;
	endfunction

	task automatic add_word(cmd_t c, longint a, longint b);
		req_word_t w;
		w.command = c;
		w.left_operand = a;
		w.right_operand = b;
		pending_words.push_back(w);
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_results.push_back(alu_predict(request));
				gap = $urandom_range(0, 5);
			end
			if (start && busy) begin
				// hold
			end else if (gap > 0 || drain_hold || pending_words.size() == 0) begin
				start <= 1'b0;
				if (gap > 0 && !(start && !busy)) gap = gap - 1;
			end else begin
				start <= 1'b1;
				request <= pending_words.pop_front();
			end
		end
	end

	always @(posedge clk) begin
		res_word_t exp_r;
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result with no word pending: value %0d status %0d",
					result.value, result.status);
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (result.value !== exp_r.value) begin
					$error("value: expected %0d actual %0d", exp_r.value, result.value);
					errors++;
				end
				if (result.status !== exp_r.status) begin
					$error("status: expected %0d actual %0d", exp_r.status, result.status);
					errors++;
				end
			end
		end
	end

	initial begin
		int k;
		cmd_t c;
		add_word(CMD_ADD, MAXV, 1);
		add_word(CMD_ADD, MINV, -1);
		add_word(CMD_SUB, MINV, 1);
		add_word(CMD_MUL, MINV, -1);
		add_word(CMD_MUL, 64'sh100000000, 64'sh7fffffff);
		add_word(CMD_DIV, 7, 0);
		add_word(CMD_DIV, MINV, -1);
		add_word(CMD_DIV, 7, 2);
		add_word(CMD_DIV, -8, 2);
		add_word(CMD_MOD, 5, 0);
		add_word(CMD_MOD, MINV, -1);
		add_word(CMD_MOD, -7, 3);
		add_word(CMD_POW, 2, 62);
		add_word(CMD_POW, 2, 63);
		add_word(CMD_POW, -2, 63);
		add_word(CMD_POW, MAXV, 0);
		add_word(CMD_POW, 3, -1);
		add_word(CMD_AND, -1, MINV);
		add_word(CMD_OR, 0, MAXV);
		add_word(CMD_XOR, -1, MAXV);
		add_word(CMD_SHL, -1, 65);
		add_word(CMD_SHR, MINV, -1);
		add_word(CMD_NEG, MINV, 0);
		add_word(cmd_t'(4'd15), -1, -1);
		add_word(CMD_NEG, MAXV, 0);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_words.size() == 0);
		drain_hold = 1'b1;
		wait (expected_results.size() == 0 && !busy);
		drain_hold = 1'b0;
		for (k = 0; k < 550; k++) begin
			c = cmd_t'($urandom_range(0, 20) > 19 ? $urandom_range(12, 15)
				: $urandom_range(0, 11));
			if (c == CMD_POW)
				add_word(c, $signed(longint'($urandom_range(0, 8))) - 4,
					$urandom_range(0, 5) == 0 ? rand_operand() : $urandom_range(0, 70));
			else if (c == CMD_DIV && $urandom_range(0, 1))
				add_word(c, rand_operand() & 64'shffff, $urandom_range(1, 16));
			else
				add_word(c, rand_operand(), rand_operand());
		end
		wait (pending_words.size() == 0);
		@(posedge clk);
		wait (expected_results.size() == 0 && !start);
		repeat (300) @(posedge clk);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
